FILE: hw/rtl/positional_list_store_assert.svh
// assertion macros used by the checker file
`ifndef POSITIONAL_LIST_STORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define PLS_ASSERT_NOW(lbl, clk, rstn, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |-> (cond)) \
        else $error("pls check failed");

// condition must hold in the cycle after the trigger
`define PLS_ASSERT_NEXT(lbl, clk, rstn, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |=> (cond)) \
        else $error("pls check failed");

`endif

FILE: hw/rtl/pls_pkg.sv
// package with sizes, codes and types of the positional list store
`timescale 1ns / 1ps
package pls_pkg;

    localparam int CAPACITY    = 64;
    localparam int ENTRY_WIDTH = 32;

    localparam int ACT_W     = 2;
    localparam int POS_W     = 7;
    localparam int SEC_W     = 6;
    localparam int IN_W      = 32;
    localparam int OUT_W     = 32;
    localparam int STAT_W    = 2;
    localparam int CNT_OUT_W = 7;

    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SWAP   = 2'd2;
    localparam logic [ACT_W-1:0] ACT_GET    = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic                   wr_en;
        logic [ADDR_W-1:0]      wr_addr;
        logic [ENTRY_WIDTH-1:0] wr_data;
        logic                   rd_en;
        logic [ADDR_W-1:0]      rd_addr;
    } t_mem_req;

endpackage

FILE: hw/rtl/pls_ifs.sv
// request and response channel interfaces
`timescale 1ns / 1ps
interface pls_req_if import pls_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    logic [POS_W-1:0] position;
    logic [SEC_W-1:0] second_position;
    logic [IN_W-1:0]  entry_in;

    modport source (output valid, action, position, second_position, entry_in,
                    input ready);
    modport sink (input valid, action, position, second_position, entry_in,
                  output ready);
endinterface

interface pls_rsp_if import pls_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [OUT_W-1:0]     entry_out;
    logic [STAT_W-1:0]    status;
    logic [CNT_OUT_W-1:0] count;

    modport source (output valid, entry_out, status, count, input ready);
    modport sink (input valid, entry_out, status, count, output ready);
endinterface

FILE: hw/rtl/pls_entry_ram.sv
// entry memory: one write port, one read port with registered data
`timescale 1ns / 1ps
module pls_entry_ram import pls_pkg::*; (
    input  logic                   i_clk,
    input  t_mem_req               i_req,
    output logic [ENTRY_WIDTH-1:0] o_rd_data
);

    logic [ENTRY_WIDTH-1:0] mem [CAPACITY];
    logic [ENTRY_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/positional_list_store.sv
// top level of the positional list store
`timescale 1ns / 1ps
// Ordered store of up to CAPACITY entry words held in one single-port-write,
// registered-read memory, with a count register beside it. One request is
// worked on at a time; a new request is taken whenever the engine is idle,
// even while the previous result still waits in the output register. An insert
// at position p or a remove moves the entries behind p through the memory
// one per cycle; appending at the end and every error go straight to the
// result. No clearing pass is needed after reset.
module positional_list_store import pls_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    pls_req_if.sink   i_req,
    pls_rsp_if.source o_rsp
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_UP     = 4'd1;
    localparam logic [3:0] S_UP_FIN = 4'd2;
    localparam logic [3:0] S_DN     = 4'd3;
    localparam logic [3:0] S_SW_Q   = 4'd4;
    localparam logic [3:0] S_SW_WP  = 4'd5;
    localparam logic [3:0] S_SW_WQ  = 4'd6;
    localparam logic [3:0] S_GET    = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;

    logic [3:0]             r_state, n_state;
    logic [CNT_W-1:0]       r_held, n_held;
    logic                   r_out_valid, n_out_valid;
    logic [OUT_W-1:0]       r_out_entry, n_out_entry;
    logic [STAT_W-1:0]      r_out_status, n_out_status;
    logic [CNT_OUT_W-1:0]   r_out_count, n_out_count;
    logic [ADDR_W-1:0]      r_p, n_p;
    logic [ADDR_W-1:0]      r_q, n_q;
    logic [ADDR_W-1:0]      r_ra, n_ra;
    logic [ADDR_W-1:0]      r_wa, n_wa;
    logic [ADDR_W-1:0]      r_last, n_last;
    logic                   r_go, n_go;
    logic                   r_wv, n_wv;
    logic                   r_first, n_first;
    logic                   r_cap, n_cap;
    logic [ENTRY_WIDTH-1:0] r_word, n_word;
    logic [ENTRY_WIDTH-1:0] r_tmp, n_tmp;
    logic [ENTRY_WIDTH-1:0] r_res_entry, n_res_entry;
    logic [STAT_W-1:0]      r_res_status, n_res_status;

    t_mem_req               mem_req;
    logic [ENTRY_WIDTH-1:0] rd_data;

    logic                   in_fire;
    logic [CMP_W-1:0]       p_c, q_c, h_c;
    logic [ADDR_W-1:0]      pa, qa, held_last;
    logic                   is_full;

    assign in_fire   = i_req.valid && (r_state == S_IDLE);
    assign p_c       = CMP_W'(i_req.position);
    assign q_c       = CMP_W'(i_req.second_position);
    assign h_c       = CMP_W'(r_held);
    assign pa        = p_c[ADDR_W-1:0];
    assign qa        = q_c[ADDR_W-1:0];
    assign held_last = ADDR_W'(r_held - CNT_W'(1));
    assign is_full   = (r_held == CNT_W'(CAPACITY));

    always_comb begin
        n_state      = r_state;
        n_held       = r_held;
        n_out_valid  = r_out_valid;
        n_out_entry  = r_out_entry;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        n_p          = r_p;
        n_q          = r_q;
        n_ra         = r_ra;
        n_wa         = r_wa;
        n_last       = r_last;
        n_go         = r_go;
        n_wv         = r_wv;
        n_first      = r_first;
        n_cap        = r_cap;
        n_word       = r_word;
        n_tmp        = r_tmp;
        n_res_entry  = r_res_entry;
        n_res_status = r_res_status;

        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = r_wa;
        mem_req.wr_data = rd_data;
        mem_req.rd_en   = 1'b0;
        mem_req.rd_addr = r_ra;

        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_p          = pa;
                    n_q          = qa;
                    n_word       = ENTRY_WIDTH'(i_req.entry_in);
                    n_res_entry  = '0;
                    n_res_status = ST_OK;
                    n_go         = 1'b1;
                    n_wv         = 1'b0;
                    n_first      = 1'b1;
                    n_cap        = 1'b0;
                    n_state      = S_FIN;
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = pa;
                    case (i_req.action)
                        ACT_INSERT: begin
                            if (p_c > h_c) begin
                                n_res_status = ST_RANGE;
                            end else if (is_full) begin
                                n_res_status = ST_FULL;
                            end else if (p_c == h_c) begin
                                mem_req.rd_en   = 1'b0;
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = pa;
                                mem_req.wr_data = ENTRY_WIDTH'(i_req.entry_in);
                                n_held          = r_held + CNT_W'(1);
                            end else begin
                                n_ra    = held_last;
                                n_state = S_UP;
                            end
                        end
                        ACT_REMOVE: begin
                            if (p_c >= h_c) begin
                                n_res_status = ST_RANGE;
                            end else begin
                                n_ra    = pa;
                                n_last  = held_last;
                                n_state = S_DN;
                            end
                        end
                        ACT_SWAP: begin
                            if (p_c >= h_c || q_c >= h_c) begin
                                n_res_status = ST_RANGE;
                            end else if (p_c != q_c) begin
                                n_state = S_SW_Q;
                            end
                        end
                        default: begin
                            if (p_c >= h_c) begin
                                n_res_status = ST_RANGE;
                            end else begin
                                n_state = S_GET;
                            end
                        end
                    endcase
                end
            end
            // move entries up, from the end down to the target
            S_UP: begin
                mem_req.rd_en = r_go;
                mem_req.wr_en = r_wv;
                if (r_go) begin
                    n_wa = r_ra + ADDR_W'(1);
                    n_wv = 1'b1;
                    if (r_ra == r_p) begin
                        n_go = 1'b0;
                    end else begin
                        n_ra = r_ra - ADDR_W'(1);
                    end
                end else begin
                    n_wv    = 1'b0;
                    n_state = S_UP_FIN;
                end
            end
            S_UP_FIN: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = r_p;
                mem_req.wr_data = r_word;
                n_held          = r_held + CNT_W'(1);
                n_state         = S_FIN;
            end
            // first read is the removed entry, the rest move down
            S_DN: begin
                mem_req.rd_en = r_go;
                mem_req.wr_en = r_wv;
                if (r_cap) begin
                    n_res_entry = rd_data;
                end
                if (r_go) begin
                    n_wa    = r_ra - ADDR_W'(1);
                    n_wv    = !r_first;
                    n_cap   = r_first;
                    n_first = 1'b0;
                    if (r_ra == r_last) begin
                        n_go = 1'b0;
                    end else begin
                        n_ra = r_ra + ADDR_W'(1);
                    end
                end else begin
                    n_held  = r_held - CNT_W'(1);
                    n_state = S_FIN;
                end
            end
            S_SW_Q: begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = r_q;
                n_tmp           = rd_data;
                n_state         = S_SW_WP;
            end
            S_SW_WP: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = r_p;
                n_state         = S_SW_WQ;
            end
            S_SW_WQ: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = r_q;
                mem_req.wr_data = r_tmp;
                n_state         = S_FIN;
            end
            S_GET: begin
                n_res_entry = rd_data;
                n_state     = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_entry  = OUT_W'(r_res_entry);
                    n_out_status = r_res_status;
                    n_out_count  = CNT_OUT_W'(r_held);
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_held      <= '0;
            r_out_valid <= 1'b0;
            r_go        <= 1'b0;
            r_wv        <= 1'b0;
            r_first     <= 1'b0;
            r_cap       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_held      <= n_held;
            r_out_valid <= n_out_valid;
            r_go        <= n_go;
            r_wv        <= n_wv;
            r_first     <= n_first;
            r_cap       <= n_cap;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_entry  <= n_out_entry;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
        r_p          <= n_p;
        r_q          <= n_q;
        r_ra         <= n_ra;
        r_wa         <= n_wa;
        r_last       <= n_last;
        r_word       <= n_word;
        r_tmp        <= n_tmp;
        r_res_entry  <= n_res_entry;
        r_res_status <= n_res_status;
    end

    pls_entry_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.entry_out = r_out_entry;
    assign o_rsp.status    = r_out_status;
    assign o_rsp.count     = r_out_count;

endmodule

FILE: hw/rtl/pls_checker.sv
// port-level checker for the positional list store and its bind
`timescale 1ns / 1ps
`include "positional_list_store_assert.svh"
module pls_checker import pls_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_rsp_valid,
    input logic                 i_rsp_ready,
    input logic [OUT_W-1:0]     i_rsp_entry_out,
    input logic [STAT_W-1:0]    i_rsp_status,
    input logic [CNT_OUT_W-1:0] i_rsp_count
);

    `PLS_ASSERT_NOW(a_status_code, i_clk, i_rst_n, i_rsp_valid,
        i_rsp_status == ST_OK || i_rsp_status == ST_RANGE || i_rsp_status == ST_FULL)
    `PLS_ASSERT_NOW(a_error_no_entry, i_clk, i_rst_n,
        i_rsp_valid && i_rsp_status != ST_OK, i_rsp_entry_out == '0)
    `PLS_ASSERT_NOW(a_full_count, i_clk, i_rst_n,
        i_rsp_valid && i_rsp_status == ST_FULL, i_rsp_count == CNT_OUT_W'(CAPACITY))
    `PLS_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n,
        i_rsp_valid && !i_rsp_ready, i_rsp_valid)

endmodule

bind positional_list_store pls_checker u_pls_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_rsp_valid     (o_rsp.valid),
    .i_rsp_ready     (o_rsp.ready),
    .i_rsp_entry_out (o_rsp.entry_out),
    .i_rsp_status    (o_rsp.status),
    .i_rsp_count     (o_rsp.count)
);
